// ===== hdl/acb_pkg.sv =====
// Shared types and constants for the ARGB canvas alpha blend block.
package acb_pkg;

   // Field widths of the request and response beats.
   localparam int CMD_W   = 2;
   localparam int POS_X_W = 4;
   localparam int POS_Y_W = 3;
   localparam int PIXEL_W = 32;
   localparam int CHAN_W  = 8;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BLEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // Alpha value of a fully opaque pixel.
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Sequencer states.
   typedef enum logic [1:0] {
      ACB_IDLE,
      ACB_MULTIPLY,
      ACB_MIX
   } acb_state_type;

endpackage

// ===== hdl/argb_canvas_alpha_blend_top.sv =====
// Top level of the ARGB canvas: frame store, command sequencer and response register.
//
// The request channel carries one pixel command per beat: a command code, a
// pixel column and row, and an ARGB color word. Each request returns exactly
// one response beat holding the word stored at that pixel after the command;
// a position off the canvas leaves the store alone and answers zero.
// Commands are handled one at a time. A request is taken in the idle state,
// where the frame store is read into a register; the channel products are
// registered in the multiply state, and in the mix state, once the response
// register is free, the result is written back and loaded into that register.
// No new request is taken until the sequencer is back in idle, as the
// read-modify-write uses the single frame store port. The response beat is
// offered from the edge that writes the pixel back.
// While the receiver stalls, the finished response holds in its register and
// the block still takes the next request; that request waits in the last
// step until the response register is free. Reset empties the response
// register and marks every pixel unwritten, so the whole canvas reads as
// zero at once, with no clearing pass.
module argb_canvas_alpha_blend_top
   import acb_pkg::*;
#(
   parameter int CANVAS_WIDTH  = 12,
   parameter int CANVAS_HEIGHT = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [POS_X_W-1:0] req_pos_x,
   input  logic [POS_Y_W-1:0] req_pos_y,
   input  logic [PIXEL_W-1:0] req_pixel_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PIXEL_W-1:0] rsp_result_pixel
);

   localparam int DEPTH  = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   acb_state_type state_ff, state_in;

   logic [PIXEL_W-1:0] frame_store_ff [DEPTH];
   logic [DEPTH-1:0]   valid_ff;

   logic [CMD_W-1:0]   cmd_ff;
   logic [PIXEL_W-1:0] color_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               on_canvas_ff;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               rd_valid_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff;

   logic               req_accept;
   logic               on_canvas;
   logic [ADDR_W-1:0]  req_addr;
   logic [PIXEL_W-1:0] back_word;
   logic [PIXEL_W-1:0] blended;
   logic [PIXEL_W-1:0] result_word;
   logic               rsp_free;
   logic               blend_load;
   logic               finish;
   logic               store_write;

   // Address of the requested pixel; off-canvas requests point at word zero.
   assign on_canvas = (32'(req_pos_x) < CANVAS_WIDTH) && (32'(req_pos_y) < CANVAS_HEIGHT);
   assign req_addr  = on_canvas ?
                      (ADDR_W'(req_pos_x) + ADDR_W'(req_pos_y) * ADDR_W'(CANVAS_WIDTH)) :
                      '0;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ACB_IDLE:     if (req_valid) state_in = ACB_MULTIPLY;
         ACB_MULTIPLY: state_in = ACB_MIX;
         ACB_MIX:      if (rsp_free) state_in = ACB_IDLE;
         default:      state_in = ACB_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall  = 1'b1;
      blend_load = 1'b0;
      finish     = 1'b0;
      case (state_ff)
         ACB_IDLE:     req_stall  = 1'b0;
         ACB_MULTIPLY: blend_load = 1'b1;
         ACB_MIX:      finish     = rsp_free;
         default:      req_stall  = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ACB_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the request beat and read the addressed pixel.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff       <= req_cmd;
         color_ff     <= req_pixel_color;
         addr_ff      <= req_addr;
         on_canvas_ff <= on_canvas;
         rd_data_ff   <= frame_store_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rd_valid_ff <= valid_ff[req_addr];
      end
   end

   // A pixel never written since reset reads as zero.
   assign back_word = rd_valid_ff ? rd_data_ff : '0;

   acb_blend u_blend (
      .clock   (clock),
      .load    (blend_load),
      .front   (color_ff),
      .back    (back_word),
      .blended (blended)
   );

   // Word held at the pixel after the command.
   always_comb begin
      case (cmd_ff)
         CMD_WRITE: result_word = color_ff;
         CMD_BLEND: result_word = blended;
         default:   result_word = back_word;
      endcase
      if (!on_canvas_ff) begin
         result_word = '0;
      end
   end

   assign store_write = finish && on_canvas_ff && (cmd_ff inside {CMD_WRITE, CMD_BLEND});

   // Frame store write-back.
   always_ff @(posedge clock) begin
      if (store_write) begin
         frame_store_ff[addr_ff] <= result_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (store_write) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_pixel_ff <= result_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_pixel_ff;

endmodule

// ===== hdl/acb_blend.sv =====
// Two-step "over" compositing unit: registered channel products, then mix and divide by 255.
module acb_blend
   import acb_pkg::*;
(
   input  logic               clock,
   input  logic               load,
   input  logic [PIXEL_W-1:0] front,
   input  logic [PIXEL_W-1:0] back,
   output logic [PIXEL_W-1:0] blended
);

   logic [2*CHAN_W-1:0] prod_back_ff  [3];
   logic [2*CHAN_W-1:0] prod_front_ff [3];
   logic [CHAN_W-1:0]   chan_mix      [3];

   // Exact floor(v / 255) for any v up to 255 * 255, by reciprocal and correction.
   function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] v);
      logic [2*CHAN_W:0] t;
      t = {1'b0, v} + 17'd1 + {9'd0, v[2*CHAN_W-1:CHAN_W]};
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

   // Products of each RGB channel with its weight.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int c = 0; c < 3; c++) begin
            prod_back_ff[c]  <= back[c*CHAN_W +: CHAN_W] *
                                (ALPHA_OPAQUE - front[3*CHAN_W +: CHAN_W]);
            prod_front_ff[c] <= front[c*CHAN_W +: CHAN_W] * front[3*CHAN_W +: CHAN_W];
         end
      end
   end

   // Sum the weighted channels and scale back to eight bits.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         chan_mix[c] = div255(prod_back_ff[c] + prod_front_ff[c]);
      end
   end

   assign blended = {ALPHA_OPAQUE, chan_mix[2], chan_mix[1], chan_mix[0]};

endmodule
